FILE: rtl/akmf_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// akmf_pkg - shared constants for the key ladder median filter
// Register map codes and key count used by the window check and top level.
// ----------------------------------------------------------------------------
package akmf_pkg;

    // number of configured key levels
    localparam int KEY_COUNT    = 6;
    // register index width on the configuration port
    localparam int CFG_IDX_BITS = 3;

    // configuration register map
    typedef enum logic [CFG_IDX_BITS-1:0] {
        REG_KEY_LEVEL_0  = 3'd0,
        REG_KEY_LEVEL_1  = 3'd1,
        REG_KEY_LEVEL_2  = 3'd2,
        REG_KEY_LEVEL_3  = 3'd3,
        REG_KEY_LEVEL_4  = 3'd4,
        REG_KEY_LEVEL_5  = 3'd5,
        REG_LEVEL_WINDOW = 3'd6
    } t_reg_idx;

endpackage

FILE: rtl/akmf_window.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// akmf_window - key level window check
// Flags a sample lying within +/- window of any configured key level.
// Lower bound clamps at zero, upper bound is formed one bit wider.
// ----------------------------------------------------------------------------
module akmf_window #(
    parameter int SAMPLE_BITS = 12
) (
    input  logic [SAMPLE_BITS-1:0] i_sample,
    input  logic [SAMPLE_BITS-1:0] i_key_level [akmf_pkg::KEY_COUNT],
    input  logic [SAMPLE_BITS-1:0] i_level_window,
    output logic                   o_is_key
);

    logic [akmf_pkg::KEY_COUNT-1:0] w_hit;

    // one independent bound check per key
    always_comb begin
        logic [SAMPLE_BITS-1:0] lo;
        logic [SAMPLE_BITS:0]   hi;
        for (int k = 0; k < akmf_pkg::KEY_COUNT; k++) begin
            lo = (i_key_level[k] > i_level_window) ? (i_key_level[k] - i_level_window)
                                                   : '0;
            hi = {1'b0, i_key_level[k]} + {1'b0, i_level_window};
            w_hit[k] = (i_sample >= lo) && ({1'b0, i_sample} <= hi);
        end
    end

    assign o_is_key = |w_hit;

endmodule

FILE: rtl/akmf_cell.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// akmf_cell - one slot of the insertion sorting chain
// Holds one sample; on insert it keeps its value, takes the new sample, or
// takes its lower neighbour's value so the chain stays sorted ascending.
// ----------------------------------------------------------------------------
module akmf_cell #(
    parameter int SAMPLE_BITS = 12
) (
    input  logic                   i_clk,
    input  logic                   i_ins,       // insert strobe
    input  logic                   i_occ,       // slot holds a sample of this run
    input  logic [SAMPLE_BITS-1:0] i_new,       // sample being inserted
    input  logic                   i_prev_lt,   // new sample goes below neighbour
    input  logic [SAMPLE_BITS-1:0] i_prev_val,  // neighbour's value
    output logic                   o_lt,
    output logic [SAMPLE_BITS-1:0] o_val,
    output logic [SAMPLE_BITS-1:0] o_next
);

    logic [SAMPLE_BITS-1:0] r_val;

    // empty slots behave as +infinity
    assign o_lt = !i_occ || (i_new < r_val);

    // shift up from the neighbour, or drop the new sample in here
    always_comb begin
        if (!o_lt) begin
            o_next = r_val;
        end else if (i_prev_lt) begin
            o_next = i_prev_val;
        end else begin
            o_next = i_new;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_ins) begin
            r_val <= o_next;
        end
    end

    assign o_val = r_val;

endmodule

FILE: rtl/adc_key_median_filter_unit.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// adc_key_median_filter_unit - median filter for resistor ladder key samples
// Window check against six key levels, then a chain of sorting cells that
// keeps the current run in order; the middle cell gives the median.
// ----------------------------------------------------------------------------
//  channel   | dir | transfer moves
//  s_axis    | in  | tdata: sample
//  m_axis    | out | tdata: median_value; tuser: key_held
//  i_cfg_*   | in  | register index and value, one write per enabled cycle
//
//  One sample per cycle sustained unless the output waits: stage one
//  registers the window result, stage two inserts into the cell chain.
//  Stage one and then the output register lie between input and result.
//  Input stalls only while stage one is full and the output register waits.
//  Sync reset clears control state and config registers; no clearing pass.
// ----------------------------------------------------------------------------
module adc_key_median_filter_unit #(
    parameter int SAMPLE_COUNT = 5,
    parameter int SAMPLE_BITS  = 12
) (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    // input stream, tdata: sample
    input  logic                                s_axis_tvalid,
    output logic                                s_axis_tready,
    input  logic [((SAMPLE_BITS+7)/8)*8-1:0]    s_axis_tdata,
    // output stream, tdata: median_value
    output logic                                m_axis_tvalid,
    input  logic                                m_axis_tready,
    output logic [((SAMPLE_BITS+7)/8)*8-1:0]    m_axis_tdata,
    // tuser: key_held
    output logic                                m_axis_tuser,
    // configuration writes
    input  logic                                i_cfg_we,
    input  logic [akmf_pkg::CFG_IDX_BITS-1:0]   i_cfg_idx,
    input  logic [SAMPLE_BITS-1:0]              i_cfg_data
);

    localparam int FILL_BITS = $clog2(SAMPLE_COUNT);
    localparam int HALF      = SAMPLE_COUNT / 2;

    // configuration registers
    logic [SAMPLE_BITS-1:0] r_key_level [akmf_pkg::KEY_COUNT];
    logic [SAMPLE_BITS-1:0] r_level_window;

    // stage one
    logic                   r_s1_valid;
    logic [SAMPLE_BITS-1:0] r_s1_sample;
    logic                   r_s1_key;

    // run state
    logic [FILL_BITS-1:0]   r_fill;
    logic                   r_held;

    // output register
    logic                   r_out_valid;
    logic [SAMPLE_BITS-1:0] r_med;
    logic                   r_out_held;

    logic                   w_is_key;
    logic                   w_s1_adv;
    logic                   w_ins;
    logic                   w_emit;
    logic                   w_in_xfer;

    logic [SAMPLE_COUNT-1:0] w_occ;
    logic [SAMPLE_COUNT-1:0] w_lt;
    logic [SAMPLE_COUNT-1:0] w_prev_lt;
    logic [SAMPLE_BITS-1:0]  w_val      [SAMPLE_COUNT];
    logic [SAMPLE_BITS-1:0]  w_next     [SAMPLE_COUNT];
    logic [SAMPLE_BITS-1:0]  w_prev_val [SAMPLE_COUNT];

    // register writes
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int k = 0; k < akmf_pkg::KEY_COUNT; k++) begin
                r_key_level[k] <= '0;
            end
            r_level_window <= '0;
        end else if (i_cfg_we) begin
            case (akmf_pkg::t_reg_idx'(i_cfg_idx))
                akmf_pkg::REG_KEY_LEVEL_0:  r_key_level[0] <= i_cfg_data;
                akmf_pkg::REG_KEY_LEVEL_1:  r_key_level[1] <= i_cfg_data;
                akmf_pkg::REG_KEY_LEVEL_2:  r_key_level[2] <= i_cfg_data;
                akmf_pkg::REG_KEY_LEVEL_3:  r_key_level[3] <= i_cfg_data;
                akmf_pkg::REG_KEY_LEVEL_4:  r_key_level[4] <= i_cfg_data;
                akmf_pkg::REG_KEY_LEVEL_5:  r_key_level[5] <= i_cfg_data;
                akmf_pkg::REG_LEVEL_WINDOW: r_level_window <= i_cfg_data;
                default: ;
            endcase
        end
    end

    // window check on the incoming sample
    akmf_window #(.SAMPLE_BITS(SAMPLE_BITS)) u_window (
        .i_sample       (s_axis_tdata[SAMPLE_BITS-1:0]),
        .i_key_level    (r_key_level),
        .i_level_window (r_level_window),
        .o_is_key       (w_is_key)
    );

    // handshake
    assign w_s1_adv      = r_s1_valid && (!r_out_valid || m_axis_tready);
    assign s_axis_tready = !r_s1_valid || w_s1_adv;
    assign w_in_xfer     = s_axis_tvalid && s_axis_tready;

    // stage one register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_valid <= 1'b0;
        end else if (w_in_xfer) begin
            r_s1_valid <= 1'b1;
        end else if (w_s1_adv) begin
            r_s1_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_in_xfer) begin
            r_s1_sample <= s_axis_tdata[SAMPLE_BITS-1:0];
            r_s1_key    <= w_is_key;
        end
    end

    // a release sample is dropped; anything else goes into the chain
    assign w_ins  = w_s1_adv && (r_s1_key || !r_held);
    assign w_emit = w_ins && (r_fill == FILL_BITS'(SAMPLE_COUNT - 1));

    // sorting chain, slots below the fill count are live
    for (genvar g = 0; g < SAMPLE_COUNT; g++) begin : g_cell
        assign w_occ[g] = (FILL_BITS'(g) < r_fill);
        if (g == 0) begin : g_first
            assign w_prev_lt[g]  = 1'b0;
            assign w_prev_val[g] = '0;
        end else begin : g_rest
            assign w_prev_lt[g]  = w_lt[g-1];
            assign w_prev_val[g] = w_val[g-1];
        end
        akmf_cell #(.SAMPLE_BITS(SAMPLE_BITS)) u_cell (
            .i_clk      (i_clk),
            .i_ins      (w_ins),
            .i_occ      (w_occ[g]),
            .i_new      (r_s1_sample),
            .i_prev_lt  (w_prev_lt[g]),
            .i_prev_val (w_prev_val[g]),
            .o_lt       (w_lt[g]),
            .o_val      (w_val[g]),
            .o_next     (w_next[g])
        );
    end

    // fill index and held flag
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_fill <= '0;
            r_held <= 1'b0;
        end else if (w_s1_adv) begin
            if (r_s1_key) begin
                r_held <= 1'b1;
            end else if (r_held) begin
                r_held <= 1'b0;
            end
            if (!r_s1_key && r_held) begin
                r_fill <= '0;
            end else if (w_emit) begin
                r_fill <= '0;
            end else begin
                r_fill <= r_fill + 1'b1;
            end
        end
    end

    // output register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (w_emit) begin
            r_out_valid <= 1'b1;
        end else if (m_axis_tready) begin
            r_out_valid <= 1'b0;
        end
    end

    // held flag after a stored sample equals that sample's key result
    always_ff @(posedge i_clk) begin
        if (w_emit) begin
            r_med      <= w_next[HALF];
            r_out_held <= r_s1_key;
        end
    end

    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tuser  = r_out_held;

    always_comb begin
        m_axis_tdata                  = '0;
        m_axis_tdata[SAMPLE_BITS-1:0] = r_med;
    end

    // checks
    a_fill_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_fill < FILL_BITS'(SAMPLE_COUNT))
        else $error("fill index out of range");

    a_emit_src: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(r_out_valid) |-> $past(w_s1_adv) && $past(w_ins))
        else $error("result without a stored sample");

    a_release: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_s1_adv && !r_s1_key && r_held) |=> (r_fill == '0) && !r_held)
        else $error("release did not restart the run");

    a_key_sets: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_s1_adv && r_s1_key) |=> r_held)
        else $error("key sample did not set held flag");

endmodule
